FILE: hw/rtl/mnee_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note event extractor package
// Shared types, codes and constants of the note event extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package mnee_pkg;

   localparam int unsigned DIV_STEPS = 40;

   localparam logic [31:0] HDR_TAG   = 32'h4D54_6864;
   localparam logic [31:0] TRK_TAG   = 32'h4D54_726B;
   localparam logic [23:0] TEMPO_TAG = 24'hFF_5103;
   localparam logic [15:0] END_TAG   = 16'hFF2F;
   localparam logic [7:0]  NOTE_ON   = 8'h90;
   localparam logic [7:0]  SYNC_NOTE = 8'h45;
   localparam logic [7:0]  META_HEAD = 8'hFF;
   localparam logic [7:0]  TEMPO_CMD = 8'h51;
   localparam logic [7:0]  CTRL_HEAD = 8'hB0;
   localparam logic [7:0]  CONT_BIT  = 8'h80;
   localparam logic [7:0]  NOTE_A    = 8'd69;
   localparam logic [7:0]  NOTE_B    = 8'd71;
   localparam logic [7:0]  NOTE_C    = 8'd72;
   localparam logic [7:0]  NOTE_D    = 8'd74;
   localparam logic [30:0] TIME_MAX  = 31'h7FFF_FFFF;

   typedef enum logic [3:0] {
      PH_HDR_SEARCH   = 4'd0,
      PH_HDR_SKIP     = 4'd1,
      PH_TRK_SEARCH   = 4'd2,
      PH_TEMPO_SEARCH = 4'd3,
      PH_TEMPO_INIT   = 4'd4,
      PH_SYNC_SEARCH  = 4'd5,
      PH_DELTA        = 4'd6,
      PH_DROP_STATUS  = 4'd7,
      PH_HEAD         = 4'd8,
      PH_SECOND       = 4'd9,
      PH_TEMPO_LEN    = 4'd10,
      PH_TEMPO_EVT    = 4'd11,
      PH_B0_DROP      = 4'd12,
      PH_DONE         = 4'd13
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_MUL,
      CS_ADD,
      CS_DIV,
      CS_EMIT
   } ctrl_state_type;

   typedef enum logic {
      REC_NOTE = 1'b0,
      REC_END  = 1'b1
   } rec_kind_type;

   typedef struct packed {
      logic step;
      logic mul;
      logic add;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic want_mul;
      logic want_div;
      logic want_emit;
      logic div_last;
      logic div_emit;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mnee_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI note event extractor controller
// Sequences byte steps, the delta multiply, the tick divider and record output.
// ----------------------------------------------------------------------------
`default_nettype none

module mnee_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  mnee_pkg::status_type status,
   output mnee_pkg::cmd_type    cmd
);

   mnee_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mnee_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mnee_pkg::CS_IDLE: begin
            if (req_tvalid) begin
               if (status.want_emit) begin
                  state_in = mnee_pkg::CS_EMIT;
               end else if (status.want_div) begin
                  state_in = mnee_pkg::CS_DIV;
               end else if (status.want_mul) begin
                  state_in = mnee_pkg::CS_MUL;
               end
            end
         end
         mnee_pkg::CS_MUL: state_in = mnee_pkg::CS_ADD;
         mnee_pkg::CS_ADD: state_in = mnee_pkg::CS_IDLE;
         mnee_pkg::CS_DIV: begin
            if (status.div_last) begin
               state_in = status.div_emit ? mnee_pkg::CS_EMIT : mnee_pkg::CS_IDLE;
            end
         end
         mnee_pkg::CS_EMIT: begin
            if (status.out_free) begin
               state_in = mnee_pkg::CS_IDLE;
            end
         end
         default: state_in = mnee_pkg::CS_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == mnee_pkg::CS_IDLE);
      cmd.step     = (state_ff == mnee_pkg::CS_IDLE) && req_tvalid;
      cmd.mul      = (state_ff == mnee_pkg::CS_MUL);
      cmd.add      = (state_ff == mnee_pkg::CS_ADD);
      cmd.div_step = (state_ff == mnee_pkg::CS_DIV);
      cmd.load_out = (state_ff == mnee_pkg::CS_EMIT) && status.out_free;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mnee_dp.sv
// ----------------------------------------------------------------------------
// MIDI note event extractor datapath
// Parse state, byte window, tick divider, delta multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mnee_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  mnee_pkg::cmd_type    cmd,
   output mnee_pkg::status_type status,
   input  wire [7:0]            req_byte,
   input  wire                  req_eof,
   input  wire                  csr_valid,
   input  wire [3:0]            csr_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic                 rsp_kind,
   output logic [1:0]           rsp_light,
   output logic [30:0]          rsp_time,
   output logic [7:0]           rsp_level
);

   typedef struct packed {
      mnee_pkg::phase_type phase;
      logic                load10;
      logic                load3;
      logic                clr_delta;
   } settle_type;

   function automatic settle_type settle(input mnee_pkg::phase_type ph,
                                         input logic [31:0] win,
                                         input logic [3:0] chan);
      settle_type r;
      r = '{phase: ph, load10: 1'b0, load3: 1'b0, clr_delta: 1'b0};
      if (ph == mnee_pkg::PH_HDR_SEARCH && win == mnee_pkg::HDR_TAG) begin
         r.phase  = mnee_pkg::PH_HDR_SKIP;
         r.load10 = 1'b1;
      end else if (ph == mnee_pkg::PH_SYNC_SEARCH &&
                   win[23:0] == {mnee_pkg::NOTE_ON | {4'b0, chan}, mnee_pkg::SYNC_NOTE,
                                 8'h00}) begin
         r.phase     = mnee_pkg::PH_DELTA;
         r.clr_delta = 1'b1;
      end else begin
         if (ph == mnee_pkg::PH_TRK_SEARCH && win == mnee_pkg::TRK_TAG) begin
            r.phase = mnee_pkg::PH_TEMPO_SEARCH;
         end
         if (r.phase == mnee_pkg::PH_TEMPO_SEARCH && win[23:0] == mnee_pkg::TEMPO_TAG) begin
            r.phase = mnee_pkg::PH_TEMPO_INIT;
            r.load3 = 1'b1;
         end
      end
      return r;
   endfunction

   mnee_pkg::phase_type phase_ff, phase_in;
   logic [31:0] window_ff, window_in;
   logic [3:0]  bytes_ff, bytes_in;
   logic [15:0] tpb_ff, tpb_in;
   logic [23:0] tempo_ff, tempo_in;
   logic [39:0] tick_ff, tick_in;
   logic [30:0] elapsed_ff, elapsed_in;
   logic [27:0] delta_ff, delta_in;
   logic        skip_ff, skip_in;
   logic [7:0]  head_ff, head_in;
   logic [3:0]  chan_ff;
   logic [39:0] divq_ff, divq_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [51:0] phi_ff, phi_in;
   logic [43:0] plo_ff, plo_in;
   logic        rec_kind_ff, rec_kind_in;
   logic [1:0]  rec_light_ff, rec_light_in;
   logic [7:0]  rec_level_ff, rec_level_in;
   logic        valid_ff;
   logic        out_kind_ff;
   logic [1:0]  out_light_ff;
   logic [30:0] out_time_ff;
   logic [7:0]  out_level_ff;

   logic [31:0] win_next;
   logic [3:0]  bytes_dec;
   logic [16:0] rem_try;
   logic [53:0] sum_wide;
   logic        do_settle;
   mnee_pkg::phase_type settle_from;
   logic [31:0] settle_win;
   settle_type  s;
   logic        ee_hit;
   logic        out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mnee_pkg::PH_HDR_SEARCH;
         window_ff  <= '0;
         bytes_ff   <= '0;
         tpb_ff     <= '0;
         tempo_ff   <= '0;
         tick_ff    <= '0;
         elapsed_ff <= '0;
         delta_ff   <= '0;
         skip_ff    <= 1'b0;
         head_ff    <= '0;
         chan_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         bytes_ff   <= bytes_in;
         tpb_ff     <= tpb_in;
         tempo_ff   <= tempo_in;
         tick_ff    <= tick_in;
         elapsed_ff <= elapsed_in;
         delta_ff   <= delta_in;
         skip_ff    <= skip_in;
         head_ff    <= head_in;
         if (csr_valid) begin
            chan_ff <= csr_data;
         end
         if (cmd.load_out) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      divq_ff      <= divq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      phi_ff       <= phi_in;
      plo_ff       <= plo_in;
      rec_kind_ff  <= rec_kind_in;
      rec_light_ff <= rec_light_in;
      rec_level_ff <= rec_level_in;
      if (cmd.load_out) begin
         out_kind_ff  <= rec_kind_ff;
         out_light_ff <= rec_light_ff;
         out_time_ff  <= elapsed_ff;
         out_level_ff <= rec_level_ff;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      window_in    = window_ff;
      bytes_in     = bytes_ff;
      tpb_in       = tpb_ff;
      tempo_in     = tempo_ff;
      tick_in      = tick_ff;
      elapsed_in   = elapsed_ff;
      delta_in     = delta_ff;
      skip_in      = skip_ff;
      head_in      = head_ff;
      divq_in      = divq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      phi_in       = phi_ff;
      plo_in       = plo_ff;
      rec_kind_in  = rec_kind_ff;
      rec_light_in = rec_light_ff;
      rec_level_in = rec_level_ff;
      status       = '0;
      status.out_free = out_free;
      do_settle    = 1'b0;
      settle_from  = phase_ff;
      settle_win   = window_ff;
      win_next     = {window_ff[23:0], req_byte};
      bytes_dec    = bytes_ff - 4'd1;
      ee_hit       = 1'b0;
      rem_try      = {rem_ff[15:0], divq_ff[39]};
      sum_wide     = 54'(elapsed_ff) + 54'(phi_ff) + 54'(plo_ff[43:16]);

      if (cmd.step && phase_ff != mnee_pkg::PH_DONE) begin
         if (req_eof) begin
            rec_kind_in  = mnee_pkg::REC_END;
            rec_light_in = '0;
            rec_level_in = '0;
            phase_in     = mnee_pkg::PH_DONE;
            status.want_emit = 1'b1;
         end else begin
            window_in  = win_next;
            settle_win = win_next;
            ee_hit     = (win_next[15:0] == mnee_pkg::END_TAG);
            unique case (phase_ff)
               mnee_pkg::PH_HDR_SKIP: begin
                  bytes_in = bytes_dec;
                  if (bytes_dec == 4'd0) begin
                     tpb_in      = win_next[15:0];
                     phase_in    = mnee_pkg::PH_TRK_SEARCH;
                     do_settle   = 1'b1;
                     settle_from = mnee_pkg::PH_TRK_SEARCH;
                  end
               end
               mnee_pkg::PH_TEMPO_INIT, mnee_pkg::PH_TEMPO_EVT: begin
                  tempo_in = {tempo_ff[15:0], req_byte};
                  bytes_in = bytes_dec;
                  if (bytes_dec == 4'd0) begin
                     status.want_div = 1'b1;
                     divq_in = {tempo_in, 16'h0000};
                     rem_in  = '0;
                     cnt_in  = '0;
                  end
               end
               mnee_pkg::PH_DELTA: begin
                  if ((req_byte & mnee_pkg::CONT_BIT) != 8'h00) begin
                     delta_in = (delta_ff + {21'b0, req_byte[6:0]}) << 7;
                  end else begin
                     delta_in = delta_ff + {20'b0, req_byte};
                     status.want_mul = 1'b1;
                     phase_in = skip_ff ? mnee_pkg::PH_DROP_STATUS : mnee_pkg::PH_HEAD;
                  end
               end
               mnee_pkg::PH_DROP_STATUS: begin
                  skip_in  = 1'b0;
                  phase_in = mnee_pkg::PH_HEAD;
               end
               mnee_pkg::PH_HEAD: begin
                  head_in  = req_byte;
                  phase_in = mnee_pkg::PH_SECOND;
               end
               mnee_pkg::PH_SECOND: begin
                  if (head_ff == mnee_pkg::META_HEAD && req_byte == mnee_pkg::TEMPO_CMD) begin
                     skip_in  = 1'b1;
                     phase_in = mnee_pkg::PH_TEMPO_LEN;
                  end else if (head_ff == mnee_pkg::CTRL_HEAD) begin
                     phase_in = mnee_pkg::PH_B0_DROP;
                  end else if (head_ff == mnee_pkg::NOTE_A || head_ff == mnee_pkg::NOTE_B ||
                               head_ff == mnee_pkg::NOTE_C || head_ff == mnee_pkg::NOTE_D) begin
                     rec_kind_in  = mnee_pkg::REC_NOTE;
                     rec_light_in = (head_ff == mnee_pkg::NOTE_A) ? 2'd0 :
                                    (head_ff == mnee_pkg::NOTE_B) ? 2'd1 :
                                    (head_ff == mnee_pkg::NOTE_C) ? 2'd2 : 2'd3;
                     rec_level_in = req_byte;
                     phase_in     = mnee_pkg::PH_DELTA;
                     delta_in     = '0;
                     status.want_emit = 1'b1;
                  end else if (ee_hit) begin
                     rec_kind_in  = mnee_pkg::REC_END;
                     rec_light_in = '0;
                     rec_level_in = '0;
                     phase_in     = mnee_pkg::PH_DONE;
                     status.want_emit = 1'b1;
                  end else begin
                     phase_in = mnee_pkg::PH_DELTA;
                     delta_in = '0;
                  end
               end
               mnee_pkg::PH_TEMPO_LEN: begin
                  bytes_in = 4'd3;
                  tempo_in = '0;
                  phase_in = mnee_pkg::PH_TEMPO_EVT;
               end
               mnee_pkg::PH_B0_DROP: begin
                  skip_in = 1'b1;
                  if (ee_hit) begin
                     rec_kind_in  = mnee_pkg::REC_END;
                     rec_light_in = '0;
                     rec_level_in = '0;
                     phase_in     = mnee_pkg::PH_DONE;
                     status.want_emit = 1'b1;
                  end else begin
                     phase_in = mnee_pkg::PH_DELTA;
                     delta_in = '0;
                  end
               end
               mnee_pkg::PH_HDR_SEARCH, mnee_pkg::PH_TRK_SEARCH,
               mnee_pkg::PH_TEMPO_SEARCH, mnee_pkg::PH_SYNC_SEARCH: begin
                  do_settle = 1'b1;
               end
               default: phase_in = mnee_pkg::PH_DONE;
            endcase
         end
      end

      if (cmd.mul) begin
         phi_in = delta_ff * tick_ff[39:16];
         plo_in = delta_ff * tick_ff[15:0];
      end

      if (cmd.add) begin
         elapsed_in = (sum_wide > 54'(mnee_pkg::TIME_MAX)) ? mnee_pkg::TIME_MAX
                                                           : sum_wide[30:0];
      end

      if (cmd.div_step) begin
         if (rem_try >= {1'b0, tpb_ff}) begin
            rem_in  = rem_try - {1'b0, tpb_ff};
            divq_in = {divq_ff[38:0], 1'b1};
         end else begin
            rem_in  = rem_try;
            divq_in = {divq_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         status.div_last = (cnt_ff == 6'(mnee_pkg::DIV_STEPS - 1));
         if (status.div_last) begin
            tick_in = divq_in;
            if (phase_ff == mnee_pkg::PH_TEMPO_INIT) begin
               phase_in    = mnee_pkg::PH_SYNC_SEARCH;
               do_settle   = 1'b1;
               settle_from = mnee_pkg::PH_SYNC_SEARCH;
            end else if (window_ff[15:0] == mnee_pkg::END_TAG) begin
               rec_kind_in  = mnee_pkg::REC_END;
               rec_light_in = '0;
               rec_level_in = '0;
               phase_in     = mnee_pkg::PH_DONE;
               status.div_emit = 1'b1;
            end else begin
               phase_in = mnee_pkg::PH_DELTA;
               delta_in = '0;
            end
         end
      end

      s = settle(settle_from, settle_win, chan_ff);
      if (do_settle) begin
         phase_in = s.phase;
         if (s.load10) begin
            bytes_in = 4'd10;
         end
         if (s.load3) begin
            bytes_in = 4'd3;
            tempo_in = '0;
         end
         if (s.clr_delta) begin
            delta_in = '0;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_light = out_light_ff;
   assign rsp_time  = out_time_ff;
   assign rsp_level = out_level_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/midi_note_event_extractor.sv
// ----------------------------------------------------------------------------
// MIDI note event extractor
// Parses a MIDI file byte stream and emits note and end-of-track records.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_      in         tdata: data byte; tlast: end of file
//  rsp_      out        tdata: light, time, level; tuser: record kind
//  csr_      in         track channel write
//
// A word that ends a delta also runs the delta multiply and add, a word that
// completes a tempo value runs the bit-serial tick divider, and a word that
// produces a record also passes through the output register.
// Reset is synchronous and clears the parse state; a stalled output holds the
// block in its emit step until the record is taken.
`default_nettype none

module midi_note_event_extractor (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // [1:0] light_index, [32:2] time_us,
                                    // [40:33] level, [47:41] zero
   output logic        rsp_tuser,   // record_kind
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_data     // track_channel
);

   mnee_pkg::cmd_type    cmd;
   mnee_pkg::status_type status;
   logic [1:0]           light;
   logic [30:0]          time_us;
   logic [7:0]           level;

   mnee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mnee_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_byte  (req_tdata),
      .req_eof   (req_tlast),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_light (light),
      .rsp_time  (time_us),
      .rsp_level (level)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {7'b0, level, time_us, light};

endmodule

`default_nettype wire

FILE: hw/rtl/mnee_checker.sv
// ----------------------------------------------------------------------------
// MIDI note event extractor checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mnee_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire        rsp_tuser
);

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Output valid directly after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled output word changed.");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == 2'b0 && rsp_tdata[40:33] == 8'b0)
      else $error("End record carries light or level.");

   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser |=> !rsp_tvalid)
      else $error("Output after end record.");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:41] == 7'b0)
      else $error("Padding bits not zero.");

endmodule

bind midi_note_event_extractor mnee_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: sim/midi_note_event_extractor_tb.sv
// ----------------------------------------------------------------------------
// MIDI note event extractor testbench
// Streams one complete MIDI file through the extractor: the header, the track
// tag, the tempo and the sync pattern come first. A table of hand-written
// events follows, then generated events, and the file closes with an end of
// track or an end of file. Every record is checked against a behavioural
// model of the parser, under changing input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module midi_note_event_extractor_tb;

   typedef struct {
      mnee_pkg::rec_kind_type kind;
      logic [1:0]             light;
      logic [30:0]            stamp;
      logic [7:0]             level;
   } record_type;

   typedef struct {
      logic [7:0]   data;
      logic         eof;
      bit           typed;
      logic [1:0]   light;
      logic [7:0]   level;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;

   midi_note_event_extractor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser model state.
   logic [3:0]          channel;
   mnee_pkg::phase_type phase;
   logic [31:0]         window;
   logic [3:0]          left;
   logic [15:0]         ticks;
   logic [23:0]         tempo;
   logic [39:0]         tick_len;
   logic [30:0]         elapsed;
   logic [27:0]         delta;
   logic                skip;
   logic [7:0]          head;

   record_type pending_records[$];
   int      failures = 0;
   int      notes_seen = 0;
   int      ends_seen = 0;
   int      words_sent = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;
   int      cont_bytes = 0;

   function automatic void new_tick_length();
      if (ticks == 0) tick_len = '1;
      else tick_len = 40'(({40'd0, tempo} << 16) / ticks);
   endfunction

   function automatic void add_time();
      logic [63:0] d, add, sum;
      d = 64'(delta);
      add = d * 64'(tick_len >> 16) + ((d * 64'(tick_len[15:0])) >> 16);
      sum = 64'(elapsed) + add;
      elapsed = (sum > 64'(mnee_pkg::TIME_MAX)) ? mnee_pkg::TIME_MAX : sum[30:0];
   endfunction

   function automatic void settle();
      logic [23:0] sync;
      sync = {mnee_pkg::NOTE_ON | {4'd0, channel}, mnee_pkg::SYNC_NOTE, 8'h00};
      forever begin
         if (phase == mnee_pkg::PH_HDR_SEARCH && window == mnee_pkg::HDR_TAG) begin
            phase = mnee_pkg::PH_HDR_SKIP;
            left = 4'd10;
            return;
         end else if (phase == mnee_pkg::PH_TRK_SEARCH && window == mnee_pkg::TRK_TAG) begin
            phase = mnee_pkg::PH_TEMPO_SEARCH;
         end else if (phase == mnee_pkg::PH_TEMPO_SEARCH &&
                      window[23:0] == mnee_pkg::TEMPO_TAG) begin
            phase = mnee_pkg::PH_TEMPO_INIT;
            left = 4'd3;
            tempo = '0;
            return;
         end else if (phase == mnee_pkg::PH_SYNC_SEARCH && window[23:0] == sync) begin
            phase = mnee_pkg::PH_DELTA;
            delta = '0;
            return;
         end else begin
            return;
         end
      end
   endfunction

   function automatic void make_record(output record_type r,
                                       input mnee_pkg::rec_kind_type k,
                                       input logic [1:0] l, input logic [7:0] v);
      r.kind = k;
      r.light = l;
      r.stamp = elapsed;
      r.level = v;
   endfunction

   function automatic bit close_event(output record_type r);
      if (window[15:0] == mnee_pkg::END_TAG) begin
         make_record(r, mnee_pkg::REC_END, 2'd0, 8'd0);
         phase = mnee_pkg::PH_DONE;
         return 1'b1;
      end
      phase = mnee_pkg::PH_DELTA;
      delta = '0;
      return 1'b0;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic eof,
                                     output record_type r);
      if (phase == mnee_pkg::PH_DONE) return 1'b0;
      if (eof) begin
         make_record(r, mnee_pkg::REC_END, 2'd0, 8'd0);
         phase = mnee_pkg::PH_DONE;
         return 1'b1;
      end
      window = {window[23:0], b};
      case (phase)
         mnee_pkg::PH_HDR_SKIP: begin
            left = left - 4'd1;
            if (left == 0) begin
               ticks = window[15:0];
               phase = mnee_pkg::PH_TRK_SEARCH;
               settle();
            end
         end
         mnee_pkg::PH_TEMPO_INIT: begin
            tempo = {tempo[15:0], b};
            left = left - 4'd1;
            if (left == 0) begin
               new_tick_length();
               phase = mnee_pkg::PH_SYNC_SEARCH;
               settle();
            end
         end
         mnee_pkg::PH_DELTA: begin
            if (b & mnee_pkg::CONT_BIT) begin
               delta = (delta + 28'(b[6:0])) << 7;
            end else begin
               delta = delta + 28'(b);
               add_time();
               phase = skip ? mnee_pkg::PH_DROP_STATUS : mnee_pkg::PH_HEAD;
            end
         end
         mnee_pkg::PH_DROP_STATUS: begin
            skip = 1'b0;
            phase = mnee_pkg::PH_HEAD;
         end
         mnee_pkg::PH_HEAD: begin
            head = b;
            phase = mnee_pkg::PH_SECOND;
         end
         mnee_pkg::PH_SECOND: begin
            if (head == mnee_pkg::META_HEAD && b == mnee_pkg::TEMPO_CMD) begin
               skip = 1'b1;
               phase = mnee_pkg::PH_TEMPO_LEN;
            end else if (head == mnee_pkg::CTRL_HEAD) begin
               phase = mnee_pkg::PH_B0_DROP;
            end else if (head == mnee_pkg::NOTE_A || head == mnee_pkg::NOTE_B ||
                         head == mnee_pkg::NOTE_C || head == mnee_pkg::NOTE_D) begin
               make_record(r, mnee_pkg::REC_NOTE,
                           (head == mnee_pkg::NOTE_A) ? 2'd0 :
                           (head == mnee_pkg::NOTE_B) ? 2'd1 :
                           (head == mnee_pkg::NOTE_C) ? 2'd2 : 2'd3, b);
               phase = mnee_pkg::PH_DELTA;
               delta = '0;
               return 1'b1;
            end else begin
               return close_event(r);
            end
         end
         mnee_pkg::PH_TEMPO_LEN: begin
            left = 4'd3;
            tempo = '0;
            phase = mnee_pkg::PH_TEMPO_EVT;
         end
         mnee_pkg::PH_TEMPO_EVT: begin
            tempo = {tempo[15:0], b};
            left = left - 4'd1;
            if (left == 0) begin
               new_tick_length();
               return close_event(r);
            end
         end
         mnee_pkg::PH_B0_DROP: begin
            skip = 1'b1;
            return close_event(r);
         end
         mnee_pkg::PH_HDR_SEARCH, mnee_pkg::PH_TRK_SEARCH,
         mnee_pkg::PH_TEMPO_SEARCH, mnee_pkg::PH_SYNC_SEARCH: settle();
         default: phase = mnee_pkg::PH_DONE;
      endcase
      return 1'b0;
   endfunction

   task automatic send_word(input logic [7:0] b, input logic eof, input row_type row = '{
                            default: '0});
      record_type r;
      bit         got;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = parse_byte(b, eof, r);
      if (row.typed) begin
         if (!got) make_record(r, mnee_pkg::REC_NOTE, 2'd0, 8'd0);
         r.kind = mnee_pkg::REC_NOTE;
         r.light = row.light;
         r.level = row.level;
         got = 1'b1;
      end
      if (got) pending_records.push_back(r);
      words_sent++;
   endtask

   task automatic write_channel(input logic [3:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (59) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      channel = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Picks a byte that keeps the event stream well formed for the current phase.
   function automatic logic [7:0] event_byte();
      logic [7:0] b;
      int         r;
      r = $urandom_range(99);
      b = 8'($urandom);
      case (phase)
         mnee_pkg::PH_DELTA: begin
            if (r < 5 && cont_bytes < 3) begin
               b = b | mnee_pkg::CONT_BIT;
               cont_bytes++;
            end else begin
               b = b & 8'h7F;
               cont_bytes = 0;
            end
         end
         mnee_pkg::PH_HEAD: begin
            if (r < 60) b = (r < 15) ? mnee_pkg::NOTE_A : (r < 30) ? mnee_pkg::NOTE_B :
                            (r < 45) ? mnee_pkg::NOTE_C : mnee_pkg::NOTE_D;
            else if (r < 70) b = mnee_pkg::CTRL_HEAD;
            else if (r < 80) b = mnee_pkg::META_HEAD;
         end
         mnee_pkg::PH_SECOND:
            if (head == mnee_pkg::META_HEAD && r < 80) b = mnee_pkg::TEMPO_CMD;
         default: ;
      endcase
      if (window[7:0] == mnee_pkg::END_TAG[15:8] && b == mnee_pkg::END_TAG[7:0]) b = 8'h2E;
      return b;
   endfunction

   task automatic run_to(input mnee_pkg::phase_type target);
      while (phase != target) send_word(event_byte(), 1'b0);
   endtask

   task automatic send_file_prologue();
      bit         trk_early, sync_early;
      logic [3:0] ch;
      logic [15:0] tpb;
      int         r;
      trk_early = ($urandom_range(3) == 0);
      sync_early = ($urandom_range(3) == 0);
      ch = 4'($urandom_range(15));
      r = $urandom_range(99);
      tpb = (r < 8) ? 16'd0 : (r < 16) ? 16'hFFFF : (r < 24) ? 16'd1 :
            16'($urandom_range(24, 960));
      repeat (3) send_word(8'($urandom), 1'b0);
      write_channel(4'd0);
      for (int i = 3; i >= 0; i--) send_word(mnee_pkg::HDR_TAG[8*i +: 8], 1'b0);
      repeat (6) send_word(8'($urandom), 1'b0);
      if (trk_early) begin
         for (int i = 3; i >= 0; i--) send_word(mnee_pkg::TRK_TAG[8*i +: 8], 1'b0);
      end else begin
         repeat (2) send_word(8'($urandom), 1'b0);
         send_word(tpb[15:8], 1'b0);
         send_word(tpb[7:0], 1'b0);
      end
      write_channel(ch);
      if (!trk_early) begin
         send_word(8'($urandom), 1'b0);
         for (int i = 3; i >= 0; i--) send_word(mnee_pkg::TRK_TAG[8*i +: 8], 1'b0);
      end
      send_word(8'($urandom), 1'b0);
      for (int i = 2; i >= 0; i--) send_word(mnee_pkg::TEMPO_TAG[8*i +: 8], 1'b0);
      if (sync_early) begin
         send_word(mnee_pkg::NOTE_ON | {4'd0, ch}, 1'b0);
         send_word(mnee_pkg::SYNC_NOTE, 1'b0);
         send_word(8'h00, 1'b0);
      end else begin
         r = $urandom_range(100000, 1000000);
         for (int i = 2; i >= 0; i--) send_word(8'(r >> (8*i)), 1'b0);
         send_word(8'($urandom), 1'b0);
         send_word(mnee_pkg::NOTE_ON | {4'd0, ch}, 1'b0);
         send_word(mnee_pkg::SYNC_NOTE, 1'b0);
         send_word(8'h00, 1'b0);
      end
   endtask

   // Hand-written events, entered right after the sync pattern.
   row_type event_rows[] = '{
      '{8'h00, 0, 0, 0, 0}, '{mnee_pkg::NOTE_A, 0, 0, 0, 0}, '{8'hFF, 0, 1, 2'd0, 8'hFF},
      '{8'h7F, 0, 0, 0, 0}, '{mnee_pkg::NOTE_B, 0, 0, 0, 0}, '{8'h00, 0, 1, 2'd1, 8'h00},
      '{8'hC0, 0, 0, 0, 0}, '{8'h80, 0, 0, 0, 0}, '{8'h80, 0, 0, 0, 0},
      '{8'h80, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0}, '{mnee_pkg::NOTE_C, 0, 0, 0, 0},
      '{8'h80, 0, 1, 2'd2, 8'h80},
      '{8'h00, 0, 0, 0, 0}, '{mnee_pkg::CTRL_HEAD, 0, 0, 0, 0}, '{8'h07, 0, 0, 0, 0},
      '{8'h2F, 0, 0, 0, 0},
      '{8'h00, 0, 0, 0, 0}, '{mnee_pkg::META_HEAD, 0, 0, 0, 0},
      '{mnee_pkg::TEMPO_CMD, 0, 0, 0, 0},
      '{8'h03, 0, 0, 0, 0}, '{8'h07, 0, 0, 0, 0}, '{8'hA1, 0, 0, 0, 0},
      '{8'h20, 0, 0, 0, 0},
      '{8'h05, 0, 0, 0, 0}, '{8'h90, 0, 0, 0, 0}, '{8'h3C, 0, 0, 0, 0},
      '{8'h40, 0, 0, 0, 0}
   };

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      record_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_records.size() == 0) begin
            $error("record with none expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            e = pending_records.pop_front();
            if (rsp_tuser !== e.kind) begin
               $error("record_kind: expected %0d, got %0d", e.kind, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[1:0] !== e.light) begin
               $error("light_index: expected %0d, got %0d", e.light, rsp_tdata[1:0]);
               failures++;
            end
            if (rsp_tdata[32:2] !== e.stamp) begin
               $error("time_us: expected %0d, got %0d", e.stamp, rsp_tdata[32:2]);
               failures++;
            end
            if (rsp_tdata[40:33] !== e.level) begin
               $error("level: expected %0d, got %0d", e.level, rsp_tdata[40:33]);
               failures++;
            end
            if (e.kind == mnee_pkg::REC_NOTE) notes_seen++;
            else ends_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("midi_note_event_extractor_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int last_words;
      channel = '0;
      phase = mnee_pkg::PH_HDR_SEARCH;
      window = '0;
      left = '0;
      ticks = '0;
      tempo = '0;
      tick_len = '0;
      elapsed = '0;
      delta = '0;
      skip = 1'b0;
      head = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_channel(4'hF);
      send_file_prologue();
      foreach (event_rows[i]) send_word(event_rows[i].data, event_rows[i].eof, event_rows[i]);

      for (int p = 0; p < 4; p++) begin
         idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 10 : 86) : 0;
         stall_pct = (p == 2) ? 86 : (p == 3) ? 10 : 0;
         last_words = words_sent;
         while (words_sent - last_words < 95) send_word(event_byte(), 1'b0);
      end

      // A maximal delta drives the time to saturation before the file closes.
      run_to(mnee_pkg::PH_DELTA);
      cont_bytes = 0;
      repeat (3) send_word(8'hFF, 1'b0);
      send_word(8'h7F, 1'b0);
      run_to(mnee_pkg::PH_HEAD);
      send_word(mnee_pkg::NOTE_D, 1'b0);
      send_word(8'h01, 1'b0);
      if ($urandom_range(1)) begin
         send_word(8'($urandom), 1'b1);
      end else begin
         run_to(mnee_pkg::PH_HEAD);
         send_word(mnee_pkg::END_TAG[15:8], 1'b0);
         send_word(mnee_pkg::END_TAG[7:0], 1'b0);
      end
      send_word(8'($urandom), 1'b0);
      send_word(8'($urandom), 1'b1);
      write_channel(4'($urandom_range(15)));
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_records.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d file words over four gap and stall settings.", words_sent);
      $display("Checked %0d note records and %0d end records.", notes_seen, ends_seen);
      if (failures == 0)
         $display("midi_note_event_extractor_tb OK");
      else
         $display("midi_note_event_extractor_tb NOT OK");
      $finish;
   end

endmodule
